@@ hdl/cfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfhp_pkg
// Shared types and constants for the capture frame header parser.
// ----------------------------------------------------------------------------
package cfhp_pkg;

  localparam logic [15:0] MAX_CAPTURE = 16'd65535;

  localparam logic [2:0] LT_NULL   = 3'd0;
  localparam logic [2:0] LT_ETH    = 3'd1;
  localparam logic [2:0] LT_SLL1   = 3'd2;
  localparam logic [2:0] LT_SLL2   = 3'd3;
  localparam logic [2:0] LT_RAW    = 3'd4;
  localparam logic [2:0] LT_RESET  = LT_ETH;

  localparam logic [4:0] NULL_HDR_LEN    = 5'd4;
  localparam logic [4:0] ETH_HDR_LEN     = 5'd14;
  localparam logic [4:0] COOKED1_HDR_LEN = 5'd16;
  localparam logic [4:0] COOKED2_HDR_LEN = 5'd20;
  localparam logic [4:0] RAW_HDR_LEN     = 5'd0;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [31:0] FAMILY_LE      = 32'h0200_0000;
  localparam logic [31:0] FAMILY_BE      = 32'h0000_0002;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [6:0]  MIN_HDR_LEN    = 7'd20;
  localparam logic [3:0]  MAX_ADDR_LEN   = 4'd8;
  localparam logic [3:0]  ETH_ADDR_LEN   = 4'd6;

  localparam logic [1:0] ST_DROP = 2'd0;
  localparam logic [1:0] ST_IPV4 = 2'd1;
  localparam logic [1:0] ST_TCP  = 2'd2;

  localparam logic [2:0] REG_LINK_TYPE = 3'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] dest_mac;
    logic [63:0] source_link_addr;
    logic [3:0]  source_link_addr_len;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  payload_start;
    logic [15:0] payload_len;
  } res_t;

endpackage

@@ hdl/cfhp_parse.sv @@
// ----------------------------------------------------------------------------
// cfhp_parse
// Per-frame header state: captures header fields byte by byte and forms the
// verdict for the frame on its last byte.
// ----------------------------------------------------------------------------
module cfhp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        link_type,
  input  logic              byte_fire,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  output cfhp_pkg::res_t    res
);
  import cfhp_pkg::*;

  logic [15:0] pos_r, pos_nxt, cap_pos;
  logic [15:0] net_r, net_nxt, cap_net;
  logic [31:0] fam_r, fam_nxt, cap_fam;
  logic [7:0]  vl_r, vl_nxt, cap_vl;
  logic [7:0]  proto_r, proto_nxt, cap_proto;
  logic [3:0]  nib_r, nib_nxt, cap_nib;
  logic [47:0] dmac_r, dmac_nxt, cap_dmac;
  logic [63:0] src_r, src_nxt, cap_src;
  logic [3:0]  alen_r, alen_nxt, cap_alen;
  logic [31:0] ip_r [2];
  logic [31:0] ip_nxt [2];
  logic [31:0] cap_ip [2];
  logic [15:0] port_r [2];
  logic [15:0] port_nxt [2];
  logic [15:0] cap_port [2];

  logic [4:0]  link_len;
  logic        link_ok;

  always_comb begin
    link_ok = 1'b1;
    unique case (link_type)
      LT_NULL: link_len = NULL_HDR_LEN;
      LT_ETH:  link_len = ETH_HDR_LEN;
      LT_SLL1: link_len = COOKED1_HDR_LEN;
      LT_SLL2: link_len = COOKED2_HDR_LEN;
      LT_RAW:  link_len = RAW_HDR_LEN;
      default: begin
        link_len = RAW_HDR_LEN;
        link_ok  = 1'b0;
      end
    endcase
  end

  logic [15:0] p, q, q12, r;
  logic [5:0]  ihl4_cur;
  logic [2:0]  aidx;
  logic        aput;

  always_comb begin
    cap_pos   = pos_r;
    cap_net   = net_r;
    cap_fam   = fam_r;
    cap_vl    = vl_r;
    cap_proto = proto_r;
    cap_nib   = nib_r;
    cap_dmac  = dmac_r;
    cap_src   = src_r;
    cap_alen  = alen_r;
    cap_ip    = ip_r;
    cap_port  = port_r;
    p         = pos_r;
    q         = p - {11'd0, link_len};
    q12       = q - 16'd12;
    ihl4_cur  = {vl_r[3:0], 2'b00};
    r         = q - {10'd0, ihl4_cur};
    aidx      = '0;
    aput      = 1'b0;
    if (byte_fire && (pos_r < MAX_CAPTURE)) begin
      cap_pos = pos_r + 16'd1;
      case (link_type)
        LT_NULL: begin
          if (p < 16'd4) cap_fam = {fam_r[23:0], data_byte};
        end
        LT_ETH: begin
          if (p < 16'd6) begin
            cap_dmac = {dmac_r[39:0], data_byte};
          end else if (p < 16'd12) begin
            aput = 1'b1;
            aidx = 3'(p - 16'd6);
          end else if (p < 16'd14) begin
            cap_net = {net_r[7:0], data_byte};
          end
        end
        LT_SLL1: begin
          if (p == 16'd4) begin
            cap_alen = (data_byte != 8'd0) ? MAX_ADDR_LEN : 4'd0;
          end else if (p == 16'd5) begin
            if (alen_r != MAX_ADDR_LEN)
              cap_alen = (data_byte < 8'd8) ? data_byte[3:0] : MAX_ADDR_LEN;
          end else if (p >= 16'd6 && p < 16'd14) begin
            aput = 1'b1;
            aidx = 3'(p - 16'd6);
          end else if (p == 16'd14 || p == 16'd15) begin
            cap_net = {net_r[7:0], data_byte};
          end
        end
        LT_SLL2: begin
          if (p < 16'd2) begin
            cap_net = {net_r[7:0], data_byte};
          end else if (p == 16'd11) begin
            cap_alen = (data_byte < 8'd8) ? data_byte[3:0] : MAX_ADDR_LEN;
          end else if (p >= 16'd12 && p < 16'd20) begin
            aput = 1'b1;
            aidx = 3'(p - 16'd12);
          end
        end
        default: ;
      endcase
      if (aput)
        cap_src[{3'(3'd7 - aidx), 3'b000} +: 8] = src_r[{3'(3'd7 - aidx), 3'b000} +: 8]
                                                  | data_byte;
      if (link_ok && p >= {11'd0, link_len}) begin
        if (q == 16'd0) begin
          cap_vl = data_byte;
        end else if (q == 16'd9) begin
          cap_proto = data_byte;
        end else if (q >= 16'd12 && q < 16'd20) begin
          cap_ip[q12[2]] = {ip_r[q12[2]][23:0], data_byte};
        end
        if (q >= {9'd0, MIN_HDR_LEN} && {1'b0, ihl4_cur} >= MIN_HDR_LEN
            && q >= {10'd0, ihl4_cur}) begin
          if (r < 16'd4) begin
            cap_port[r[1]] = {port_r[r[1]][7:0], data_byte};
          end else if (r == 16'd12) begin
            cap_nib = data_byte[7:4];
          end
        end
      end
    end
  end

  logic        clr;
  assign clr = byte_fire && frame_end;

  always_comb begin
    pos_nxt     = clr ? '0 : cap_pos;
    net_nxt     = clr ? '0 : cap_net;
    fam_nxt     = clr ? '0 : cap_fam;
    vl_nxt      = clr ? '0 : cap_vl;
    proto_nxt   = clr ? '0 : cap_proto;
    nib_nxt     = clr ? '0 : cap_nib;
    dmac_nxt    = clr ? '0 : cap_dmac;
    src_nxt     = clr ? '0 : cap_src;
    alen_nxt    = clr ? '0 : cap_alen;
    ip_nxt[0]   = clr ? '0 : cap_ip[0];
    ip_nxt[1]   = clr ? '0 : cap_ip[1];
    port_nxt[0] = clr ? '0 : cap_port[0];
    port_nxt[1] = clr ? '0 : cap_port[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      net_r     <= '0;
      fam_r     <= '0;
      vl_r      <= '0;
      proto_r   <= '0;
      nib_r     <= '0;
      dmac_r    <= '0;
      src_r     <= '0;
      alen_r    <= '0;
      ip_r[0]   <= '0;
      ip_r[1]   <= '0;
      port_r[0] <= '0;
      port_r[1] <= '0;
    end else begin
      pos_r     <= pos_nxt;
      net_r     <= net_nxt;
      fam_r     <= fam_nxt;
      vl_r      <= vl_nxt;
      proto_r   <= proto_nxt;
      nib_r     <= nib_nxt;
      dmac_r    <= dmac_nxt;
      src_r     <= src_nxt;
      alen_r    <= alen_nxt;
      ip_r[0]   <= ip_nxt[0];
      ip_r[1]   <= ip_nxt[1];
      port_r[0] <= port_nxt[0];
      port_r[1] <= port_nxt[1];
    end
  end

  logic [16:0] n;
  logic [16:0] hdr;
  logic [5:0]  ihl4;
  logic [6:0]  tcp_at;
  logic [5:0]  doff4;
  logic [7:0]  pay_at;
  logic [3:0]  alen;
  logic [63:0] src_mask;
  logic        link_pass;

  always_comb begin
    n        = {1'b0, cap_pos};
    hdr      = (link_type == LT_RAW) ? 17'd1 : {12'd0, link_len};
    ihl4     = {cap_vl[3:0], 2'b00};
    tcp_at   = {2'd0, link_len} + {1'b0, ihl4};
    doff4    = {cap_nib, 2'b00};
    pay_at   = {1'b0, tcp_at} + {2'd0, doff4};
    src_mask = '0;
    res      = '0;
    alen     = '0;

    if (link_type == LT_NULL)
      link_pass = (cap_fam == FAMILY_BE) || (cap_fam == FAMILY_LE);
    else if (link_type == LT_RAW)
      link_pass = 1'b1;
    else
      link_pass = (cap_net == ETHERTYPE_IPV4);

    if (link_type == LT_ETH)
      alen = ETH_ADDR_LEN;
    else if (link_type == LT_SLL1 || link_type == LT_SLL2)
      alen = (cap_alen > MAX_ADDR_LEN) ? MAX_ADDR_LEN : cap_alen;

    for (int i = 0; i < 8; i++)
      if (4'(i) < alen) src_mask[63 - 8 * i -: 8] = 8'hFF;

    if (link_ok && n >= hdr && link_pass
        && n >= {12'd0, link_len} + {10'd0, MIN_HDR_LEN}
        && cap_vl[7:4] == IP_VERSION4 && {1'b0, ihl4} >= MIN_HDR_LEN
        && n >= {10'd0, tcp_at}) begin
      res.status               = ST_IPV4;
      res.dest_mac             = (link_type == LT_ETH) ? cap_dmac : '0;
      res.source_link_addr     = cap_src & src_mask;
      res.source_link_addr_len = alen;
      res.source_ip            = cap_ip[0];
      res.dest_ip              = cap_ip[1];
      if (cap_proto == PROTO_TCP
          && n >= {10'd0, tcp_at} + {10'd0, MIN_HDR_LEN}
          && {1'b0, doff4} >= MIN_HDR_LEN
          && n >= {9'd0, pay_at}) begin
        res.status        = ST_TCP;
        res.source_port   = cap_port[0];
        res.dest_port     = cap_port[1];
        res.payload_start = pay_at;
        res.payload_len   = 16'(n - {9'd0, pay_at});
      end
    end
  end

endmodule

@@ hdl/capture_frame_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// capture_frame_header_parser_top
// Captured frame header parser with an APB register for the link type.
// The result of a frame is registered on the transfer of its last byte, in
// the output register or, while that is stalled, the skid entry. Throughput:
// one byte per cycle, set by the per-byte field capture; a two-entry output
// buffer raises in_stall only when two results wait. Reset (synchronous)
// clears all frame state and sets link_type to ethernet.
// ----------------------------------------------------------------------------
module capture_frame_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [47:0] out_dest_mac,
  output logic [63:0] out_source_link_addr,
  output logic [3:0]  out_source_link_addr_len,
  output logic [31:0] out_source_ip,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [7:0]  out_payload_start,
  output logic [15:0] out_payload_len
);
  import cfhp_pkg::*;

  logic [2:0] link_type_r, link_type_nxt;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = ({paddr[2], 2'b00} == REG_LINK_TYPE);
  assign prdata  = reg_sel ? {29'd0, link_type_r} : '0;

  always_comb begin
    link_type_nxt = link_type_r;
    if (psel && penable && pwrite && pready && reg_sel)
      link_type_nxt = pwdata[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= LT_RESET;
    end else begin
      link_type_r <= link_type_nxt;
    end
  end

  logic  in_fire;
  res_t  res;

  assign in_fire = in_valid && !in_stall;

  cfhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .link_type (link_type_r),
    .byte_fire (in_fire),
    .data_byte (in_data_byte),
    .frame_end (in_frame_end),
    .res       (res)
  );

  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  res_t  out_r, out_nxt;
  res_t  skid_r, skid_nxt;
  logic  emit;
  logic  out_free;

  assign emit     = in_fire && in_frame_end;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = emit;
      end
    end else if (emit) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_r.status;
  assign out_dest_mac             = out_r.dest_mac;
  assign out_source_link_addr     = out_r.source_link_addr;
  assign out_source_link_addr_len = out_r.source_link_addr_len;
  assign out_source_ip            = out_r.source_ip;
  assign out_dest_ip              = out_r.dest_ip;
  assign out_source_port          = out_r.source_port;
  assign out_dest_port            = out_r.dest_port;
  assign out_payload_start        = out_r.payload_start;
  assign out_payload_len          = out_r.payload_len;

endmodule

@@ hdl/cfhp_checker.sv @@
// ----------------------------------------------------------------------------
// cfhp_checker
// Port-level checks for the capture frame header parser, bound to the top.
// ----------------------------------------------------------------------------
module cfhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [47:0] out_dest_mac,
  input logic [63:0] out_source_link_addr,
  input logic [3:0]  out_source_link_addr_len,
  input logic [31:0] out_source_ip,
  input logic [15:0] out_source_port,
  input logic [15:0] out_dest_port,
  input logic [7:0]  out_payload_start,
  input logic [15:0] out_payload_len
);
  import cfhp_pkg::*;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DROP |->
      out_dest_mac == '0 && out_source_link_addr == '0 &&
      out_source_link_addr_len == '0 && out_source_ip == '0)
    else $error("dropped result carries nonzero fields");

  a_tcp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TCP |->
      out_source_port == '0 && out_dest_port == '0 &&
      out_payload_start == '0 && out_payload_len == '0)
    else $error("tcp fields set without tcp status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DROP || out_status == ST_IPV4 ||
                  out_status == ST_TCP)
    else $error("undefined status code");

endmodule

bind capture_frame_header_parser_top cfhp_checker u_cfhp_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_stall                 (in_stall),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_status               (out_status),
  .out_dest_mac             (out_dest_mac),
  .out_source_link_addr     (out_source_link_addr),
  .out_source_link_addr_len (out_source_link_addr_len),
  .out_source_ip            (out_source_ip),
  .out_source_port          (out_source_port),
  .out_dest_port            (out_dest_port),
  .out_payload_start        (out_payload_start),
  .out_payload_len          (out_payload_len)
);
